// File: rtl/core/sirp_pkg.sv
// ----------------------------------------------------------------------------
// sirp_pkg
// Shared types and constants of the server info reply parser.
// ----------------------------------------------------------------------------
package sirp_pkg;

  localparam int MAX_RES    = 5;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_W      = $clog2(MAX_RES + 1);

  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] TYPE_CHAL  = 8'h41;
  localparam logic [7:0] TYPE_INFO  = 8'h49;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] ASCII_DEL  = 8'h7F;
  localparam logic [7:0] ASCII_SPC  = 8'h20;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_TYPE     = 4'd1,
    PH_CHAL     = 4'd2,
    PH_SKIP1    = 4'd3,
    PH_STR      = 4'd4,
    PH_SKIP2    = 4'd5,
    PH_PLAY     = 4'd6,
    PH_INFO_END = 4'd7,
    PH_CHAL_END = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_INFO = 2'd1,
    KIND_CHAL = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  string_index;
    logic [7:0]  text_byte;
    logic [31:0] challenge_value;
    logic [7:0]  players;
    logic [7:0]  max_players;
    logic [7:0]  bots;
    logic        verdict_flag;
  } result_t;

  typedef struct packed {
    logic [NUM_W-1:0]          n;
    result_t [MAX_RES-1:0]     items;
  } res_bundle_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    case (b) inside
      [LEAD2_LO:LEAD2_HI]: len = 3'd2;
      [LEAD3_LO:LEAD3_HI]: len = 3'd3;
      [LEAD4_LO:LEAD4_HI]: len = 3'd4;
      default:             len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/sirp_parse.sv
// ----------------------------------------------------------------------------
// sirp_parse
// Per-byte reply parser: header and type check, challenge, UTF-8 cleaning of
// the four strings and player counts. Gives up to five results per byte.
// ----------------------------------------------------------------------------
module sirp_parse
  import sirp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output res_bundle_t bundle
);

  phase_t      phase, phase_next;
  logic [1:0]  phase_count, phase_count_next;
  logic        bad_seen, bad_seen_next;
  logic [31:0] challenge_acc, challenge_acc_next;
  logic [7:0]  player_regs [3];
  logic [7:0]  player_regs_next [3];
  logic [7:0]  utf8_pending [3];
  logic [7:0]  utf8_pending_next [3];
  logic [1:0]  utf8_have, utf8_have_next;
  logic [2:0]  utf8_need, utf8_need_next;

  always_comb begin
    logic [7:0] text [4];
    logic [2:0] ntext;
    logic [2:0] need;
    result_t    verdict;
    result_t    tres;

    phase_next         = phase;
    phase_count_next   = phase_count;
    bad_seen_next      = bad_seen;
    challenge_acc_next = challenge_acc;
    player_regs_next   = player_regs;
    utf8_pending_next  = utf8_pending;
    utf8_have_next     = utf8_have;
    utf8_need_next     = utf8_need;
    ntext              = 3'd0;
    need               = 3'd0;
    for (int j = 0; j < 4; j++) begin
      text[j] = data_byte;
    end

    if (!bad_seen) begin
      unique case (phase)
        PH_HEADER: begin
          if (data_byte != HDR_BYTE) begin
            bad_seen_next = 1'b1;
          end else if (phase_count == 2'd3) begin
            phase_next       = PH_TYPE;
            phase_count_next = 2'd0;
          end else begin
            phase_count_next = phase_count + 2'd1;
          end
        end
        PH_TYPE: begin
          if (data_byte == TYPE_CHAL) begin
            phase_next         = PH_CHAL;
            phase_count_next   = 2'd0;
            challenge_acc_next = '0;
          end else if (data_byte == TYPE_INFO) begin
            phase_next = PH_SKIP1;
          end else begin
            bad_seen_next = 1'b1;
          end
        end
        PH_CHAL: begin
          challenge_acc_next = challenge_acc |
                               ({24'd0, data_byte} << {phase_count, 3'b000});
          if (phase_count == 2'd3) begin
            phase_next       = PH_CHAL_END;
            phase_count_next = 2'd0;
          end else begin
            phase_count_next = phase_count + 2'd1;
          end
        end
        PH_SKIP1: begin
          phase_next       = PH_STR;
          phase_count_next = 2'd0;
          utf8_have_next   = 2'd0;
          utf8_need_next   = 3'd0;
        end
        PH_STR: begin
          if (data_byte == NUL_BYTE) begin
            utf8_have_next   = 2'd0;
            utf8_need_next   = 3'd0;
            phase_count_next = phase_count + 2'd1;
            if (phase_count == 2'd3) begin
              phase_next = PH_SKIP2;
            end
          end else if (utf8_need != 3'd0 && utf8_have != 2'd0 &&
                       (data_byte & CONT_MASK) == CONT_MARK) begin
            if ({1'b0, utf8_have} + 3'd1 >= utf8_need) begin
              for (int j = 0; j < 3; j++) begin
                if (j < utf8_have) begin
                  text[j] = utf8_pending[j];
                end
              end
              ntext          = {1'b0, utf8_have} + 3'd1;
              utf8_have_next = 2'd0;
              utf8_need_next = 3'd0;
            end else begin
              for (int k = 0; k < 3; k++) begin
                if (k == utf8_have) begin
                  utf8_pending_next[k] = data_byte;
                end
              end
              utf8_have_next = utf8_have + 2'd1;
            end
          end else begin
            utf8_have_next = 2'd0;
            utf8_need_next = 3'd0;
            if (data_byte < CONT_MARK) begin
              if (data_byte >= ASCII_SPC && data_byte != ASCII_DEL) begin
                ntext = 3'd1;
              end
            end else begin
              need = lead_len(data_byte);
              if (need != 3'd0) begin
                utf8_pending_next[0] = data_byte;
                utf8_have_next       = 2'd1;
                utf8_need_next       = need;
              end
            end
          end
        end
        PH_SKIP2: begin
          if (phase_count == 2'd1) begin
            phase_next       = PH_PLAY;
            phase_count_next = 2'd0;
          end else begin
            phase_count_next = phase_count + 2'd1;
          end
        end
        PH_PLAY: begin
          for (int k = 0; k < 3; k++) begin
            if (k == phase_count) begin
              player_regs_next[k] = data_byte;
            end
          end
          if (phase_count == 2'd2) begin
            phase_next       = PH_INFO_END;
            phase_count_next = 2'd0;
          end else begin
            phase_count_next = phase_count + 2'd1;
          end
        end
        PH_INFO_END, PH_CHAL_END: begin
        end
        default: begin
          bad_seen_next = 1'b1;
        end
      endcase
    end

    verdict              = '0;
    verdict.verdict_flag = 1'b1;
    if (!bad_seen_next && phase_next == PH_INFO_END) begin
      verdict.kind        = KIND_INFO;
      verdict.players     = player_regs_next[0];
      verdict.max_players = player_regs_next[1];
      verdict.bots        = player_regs_next[2];
    end else if (!bad_seen_next && phase_next == PH_CHAL_END) begin
      verdict.kind            = KIND_CHAL;
      verdict.challenge_value = challenge_acc_next;
    end else begin
      verdict.kind = KIND_BAD;
    end

    bundle.n = NUM_W'(ntext) + NUM_W'(last_byte);
    for (int i = 0; i < MAX_RES; i++) begin
      tres              = '0;
      tres.kind         = KIND_TEXT;
      tres.string_index = phase_count;
      tres.text_byte    = (i < 4) ? text[i % 4] : data_byte;
      bundle.items[i]   = (i < ntext) ? tres : verdict;
    end

    if (last_byte) begin
      phase_next         = PH_HEADER;
      phase_count_next   = 2'd0;
      bad_seen_next      = 1'b0;
      challenge_acc_next = '0;
      for (int k = 0; k < 3; k++) begin
        player_regs_next[k] = '0;
      end
      utf8_have_next = 2'd0;
      utf8_need_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      phase_count   <= 2'd0;
      bad_seen      <= 1'b0;
      challenge_acc <= '0;
      for (int k = 0; k < 3; k++) begin
        player_regs[k] <= '0;
      end
      utf8_have <= 2'd0;
      utf8_need <= 3'd0;
    end else if (take) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      bad_seen      <= bad_seen_next;
      challenge_acc <= challenge_acc_next;
      player_regs   <= player_regs_next;
      utf8_have     <= utf8_have_next;
      utf8_need     <= utf8_need_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      utf8_pending <= utf8_pending_next;
    end
  end

endmodule

// File: rtl/core/server_info_reply_parser_core.sv
// ----------------------------------------------------------------------------
// server_info_reply_parser_core
// Streaming parser for a game-server info reply, one datagram byte in per
// transaction, cleaned text bytes and a closing verdict out.
// ----------------------------------------------------------------------------
// One datagram byte is taken per cycle as long as the eight-entry result queue
// has room for five results, the most one byte can produce. Results leave the
// queue one per cycle while m_tready is high; the output side therefore sets
// the sustained rate, one byte per cycle when each byte gives at most one
// result. The last result of a datagram carries tlast and a verdict; text that
// precedes a bad verdict is to be discarded downstream.
module server_info_reply_parser_core
  import sirp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // string_index, text_byte, challenge_value,
                                 // players, max_players, bots, zero fill
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // verdict_flag
);

  res_bundle_t      bundle;
  result_t          fifo_mem [FIFO_DEPTH];
  result_t          head;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             take, pop;

  assign take = s_tvalid && s_tready;
  assign pop  = m_tvalid && m_tready;

  sirp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .bundle    (bundle)
  );

  assign s_tready = (count <= CNT_W'(FIFO_DEPTH - MAX_RES));
  assign m_tvalid = (count != '0);
  assign head     = fifo_mem[rd_ptr];
  assign m_tuser  = head.kind;
  assign m_tlast  = head.verdict_flag;
  assign m_tdata  = {6'd0, head.bots, head.max_players, head.players,
                     head.challenge_value, head.text_byte, head.string_index};

  always_comb begin
    count_next = count;
    if (take) begin
      count_next = count_next + CNT_W'(bundle.n);
    end
    if (pop) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (take) begin
        wr_ptr <= wr_ptr + PTR_W'(bundle.n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (i < bundle.n) begin
          fifo_mem[wr_ptr + PTR_W'(i)] <= bundle.items[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count exceeds its depth");

  a_room_on_ready: assert property (@(posedge clk) disable iff (rst)
    take |=> count <= CNT_W'(FIFO_DEPTH))
    else $error("accepted byte overflowed the result queue");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (take && s_tlast) |=> (count != '0))
    else $error("final byte left no verdict in the queue");

  a_verdict_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser != KIND_TEXT))
    else $error("verdict result carries the text kind");

  a_text_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == KIND_TEXT))
    else $error("text result carries a verdict kind");
`endif

endmodule
